@@ rtl/adt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Access dependence tracker package
// Transaction types, default sizes and sequencer states shared by the tracker.
// ----------------------------------------------------------------------------
package adt_pkg;

   localparam int IdFieldBits  = 16;
   localparam int ResFieldBits = 6;

   localparam int RESOURCES_DEFAULT   = 64;
   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int ID_BITS_DEFAULT     = 16;

   typedef struct packed {
      logic [IdFieldBits-1:0]  accessor_id;
      logic [ResFieldBits-1:0] resource_index;
      logic                    final_operand;
   } req_type;

   typedef struct packed {
      logic                   edge_valid;
      logic [IdFieldBits-1:0] edge_source;
      logic [IdFieldBits-1:0] edge_target;
      logic                   queue_overflow;
      logic                   last_result;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_DRAIN
   } state_type;

endpackage : adt_pkg
`default_nettype wire

@@ rtl/adt_count_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Queue occupancy table
// Per-resource queue count memory; a valid bit per entry makes reset read zero.
// ----------------------------------------------------------------------------
module adt_count_table #(
   parameter int AddrBits = 6,
   parameter int DataBits = 5
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rd_en,
   input  wire logic [AddrBits-1:0] rd_addr,
   output logic      [DataBits-1:0] rd_data,
   input  wire logic                wr_en,
   input  wire logic [AddrBits-1:0] wr_addr,
   input  wire logic [DataBits-1:0] wr_data
);
   localparam int Depth = 2 ** AddrBits;

   logic [DataBits-1:0] mem [Depth];
   logic [Depth-1:0]    vld_ff;
   logic [DataBits-1:0] rd_data_ff;
   logic                rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule : adt_count_table
`default_nettype wire

@@ rtl/adt_entry_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Access entry store
// Single-port-write, registered-read memory holding the queued accesses.
// ----------------------------------------------------------------------------
module adt_entry_store #(
   parameter int AddrBits = 10,
   parameter int DataBits = 17
) (
   input  wire logic                clock,
   input  wire logic [AddrBits-1:0] rd_addr,
   output logic      [DataBits-1:0] rd_data,
   input  wire logic                wr_en,
   input  wire logic [AddrBits-1:0] wr_addr,
   input  wire logic [DataBits-1:0] wr_data
);
   localparam int Depth = 2 ** AddrBits;

   logic [DataBits-1:0] mem [Depth];
   logic [DataBits-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : adt_entry_store
`default_nettype wire

@@ rtl/access_dependence_tracker_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Access dependence tracker
// Tracks read/write hazards on resources and reports dependence edges.
// ----------------------------------------------------------------------------
// One access is taken when start is high and busy is low. A read fetches the
// queue count and front entry when it is accepted, then decides and queues in
// the S_LOOK state. A write stays busy in S_DRAIN while the resource queue
// is drained one entry per cycle through the single read port of the entry
// store. Results appear on rsp_payload for one cycle each with rsp_strobe high
// and cannot be stalled, so the receiver must take every result as it comes.
// A write that drains n entries gives its edges in queue order, at most one
// per cycle; entries of its own operation give no edge and leave a gap. The
// mode register is written through the csr_ channel, which is always ready;
// it should only be written while busy is low.
// ----------------------------------------------------------------------------
module access_dependence_tracker_core #(
   parameter int RESOURCES   = adt_pkg::RESOURCES_DEFAULT,
   parameter int QUEUE_DEPTH = adt_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int ID_BITS     = adt_pkg::ID_BITS_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire adt_pkg::req_type req_payload,
   output logic                 rsp_strobe,
   output adt_pkg::rsp_type     rsp_payload,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic            csr_wdata
);
   import adt_pkg::*;

   localparam int MaxRes   = 2 ** ResFieldBits;
   localparam int Entries  = (RESOURCES < MaxRes) ? RESOURCES : MaxRes;
   localparam int ResBits  = (Entries > 1) ? $clog2(Entries) : 1;
   localparam int SlotBits = $clog2(QUEUE_DEPTH);
   localparam int CntBits  = $clog2(QUEUE_DEPTH + 1);
   localparam int AddrBits = ResBits + SlotBits;
   localparam int EntBits  = ID_BITS + 1;

   state_type           state_ff, state_in;
   logic [ID_BITS-1:0]  acc_ff, acc_in;
   logic [ResBits-1:0]  res_ff, res_in;
   logic                res_ok_ff, res_ok_in;
   logic                mode_ff;
   logic [CntBits-1:0]  idx_ff, idx_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [ID_BITS-1:0]  pend_src_ff, pend_src_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   logic                accept;
   logic                write_acc;
   logic [ID_BITS-1:0]  req_id;
   logic [CntBits-1:0]  cnt;
   logic [CntBits-1:0]  idx_nxt;
   logic [EntBits-1:0]  ent;
   logic [ID_BITS-1:0]  ent_id;
   logic                ent_wr;
   logic [AddrBits-1:0] ent_rd_addr;
   logic                ent_we;
   logic [AddrBits-1:0] ent_wr_addr;
   logic [EntBits-1:0]  ent_wr_data;
   logic                cnt_we;
   logic [CntBits-1:0]  cnt_wr_data;
   logic                front_wr;
   logic                full;
   logic                id_hit;
   logic [IdFieldBits-1:0] acc_out;
   logic [IdFieldBits-1:0] front_out;
   logic [IdFieldBits-1:0] pend_out;

   generate
      if (ID_BITS <= IdFieldBits) begin : g_id_narrow
         assign req_id    = req_payload.accessor_id[ID_BITS-1:0];
         assign acc_out   = IdFieldBits'(acc_ff);
         assign front_out = IdFieldBits'(ent_id);
         assign pend_out  = IdFieldBits'(pend_src_ff);
      end else begin : g_id_wide
         assign req_id    = ID_BITS'(req_payload.accessor_id);
         assign acc_out   = acc_ff[IdFieldBits-1:0];
         assign front_out = ent_id[IdFieldBits-1:0];
         assign pend_out  = pend_src_ff[IdFieldBits-1:0];
      end
   endgenerate

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign write_acc = mode_ff || req_payload.final_operand;
   assign ent_id    = ent[ID_BITS-1:0];
   assign ent_wr    = ent[ID_BITS];
   assign idx_nxt   = idx_ff + CntBits'(1);
   assign front_wr  = (cnt != '0) && ent_wr;
   assign full      = (cnt == CntBits'(QUEUE_DEPTH));
   assign id_hit    = (ent_id == acc_ff);

   assign ent_rd_addr = (state_ff == S_IDLE)
                      ? {req_payload.resource_index[ResBits-1:0], {SlotBits{1'b0}}}
                      : {res_ff, idx_nxt[SlotBits-1:0]};

   adt_count_table #(
      .AddrBits(ResBits),
      .DataBits(CntBits)
   ) u_count (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (accept),
      .rd_addr(req_payload.resource_index[ResBits-1:0]),
      .rd_data(cnt),
      .wr_en  (cnt_we),
      .wr_addr(res_ff),
      .wr_data(cnt_wr_data)
   );

   adt_entry_store #(
      .AddrBits(AddrBits),
      .DataBits(EntBits)
   ) u_store (
      .clock  (clock),
      .rd_addr(ent_rd_addr),
      .rd_data(ent),
      .wr_en  (ent_we),
      .wr_addr(ent_wr_addr),
      .wr_data(ent_wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         pend_valid_ff <= pend_valid_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      res_ff      <= res_in;
      res_ok_ff   <= res_ok_in;
      idx_ff      <= idx_in;
      pend_src_ff <= pend_src_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      res_in        = res_ff;
      res_ok_in     = res_ok_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_src_in   = pend_src_ff;
      rsp_in        = '0;
      rsp_strobe_in = 1'b0;
      ent_we        = 1'b0;
      ent_wr_addr   = {res_ff, {SlotBits{1'b0}}};
      ent_wr_data   = {1'b0, acc_ff};
      cnt_we        = 1'b0;
      cnt_wr_data   = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               acc_in        = req_id;
               res_in        = req_payload.resource_index[ResBits-1:0];
               res_ok_in     = (32'(req_payload.resource_index) < RESOURCES);
               idx_in        = '0;
               pend_valid_in = 1'b0;
               if (write_acc && (32'(req_payload.resource_index) < RESOURCES)) begin
                  state_in = S_DRAIN;
               end else begin
                  state_in = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            state_in                = S_IDLE;
            rsp_strobe_in           = 1'b1;
            rsp_in.last_result      = 1'b1;
            if (res_ok_ff && !(front_wr && id_hit)) begin
               rsp_in.edge_valid     = front_wr;
               rsp_in.edge_source    = front_wr ? front_out : '0;
               rsp_in.edge_target    = front_wr ? acc_out : '0;
               rsp_in.queue_overflow = full;
               if (!full) begin
                  ent_we      = 1'b1;
                  ent_wr_addr = {res_ff, cnt[SlotBits-1:0]};
                  ent_wr_data = {1'b0, acc_ff};
                  cnt_we      = 1'b1;
                  cnt_wr_data = cnt + CntBits'(1);
               end
            end
         end
         S_DRAIN: begin
            if (idx_ff != cnt) begin
               idx_in = idx_nxt;
               if (!id_hit) begin
                  pend_valid_in = 1'b1;
                  pend_src_in   = ent_id;
                  if (pend_valid_ff) begin
                     rsp_strobe_in      = 1'b1;
                     rsp_in.edge_valid  = 1'b1;
                     rsp_in.edge_source = pend_out;
                     rsp_in.edge_target = acc_out;
                  end
               end
            end else begin
               state_in           = S_IDLE;
               pend_valid_in      = 1'b0;
               rsp_strobe_in      = 1'b1;
               rsp_in.last_result = 1'b1;
               rsp_in.edge_valid  = pend_valid_ff;
               rsp_in.edge_source = pend_valid_ff ? pend_out : '0;
               rsp_in.edge_target = pend_valid_ff ? acc_out : '0;
               ent_we             = 1'b1;
               ent_wr_addr        = {res_ff, {SlotBits{1'b0}}};
               ent_wr_data        = {1'b1, acc_ff};
               cnt_we             = 1'b1;
               cnt_wr_data        = CntBits'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule : access_dependence_tracker_core
`default_nettype wire
